### rtl/sfr_pkg.sv
// sfr_pkg: shared types and constants of the sensor frame receiver.
// Holds the input and result item structs, sync bytes, codes and sizes.
// No dependencies.
package sfr_pkg;

	// Largest payload length that a frame may announce
	localparam logic [7:0] PAYLOAD_MAX = 8'd100;
	// Payload bytes kept for decoding
	localparam int STORE_DEPTH = 28;
	localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;

	// Input item kinds
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Result status codes
	localparam logic STATUS_FRAME   = 1'b0;
	localparam logic STATUS_TIMEOUT = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENCODER_LIMIT = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 8'd1;

	localparam logic [30:0] ENCODER_LIMIT_RST = 31'd220;
	localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} sfr_in_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] left_delta;
		logic signed [31:0] right_delta;
		logic [31:0]        battery_word;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
	} sfr_out_t;

endpackage

### rtl/sensor_frame_receiver.sv
// sensor_frame_receiver: parser for sync-word, length-prefixed sensor frames.
// Depends on sfr_pkg (item structs, sync bytes, codes, sizes).
//
// Each input item is either a received byte or a time tick. The block watches
// the last three bytes; A5, 5A, then a length byte opens a frame and the next
// byte is payload byte 0. The pattern restarts the frame wherever it shows up;
// a length of zero or above 100 drops the frame. When the announced length is
// reached one result item is produced with the encoder deltas (zeroed when
// their magnitude exceeds encoder_limit), the battery word and eight IMU
// words, all little endian; payload bytes never received read as zero. If
// timeout_ticks ticks go by without a completed frame, a timeout result
// (status 1, all else zero) is produced. Either outcome restarts the parser.
// One item per clock unless the output stalls. Each item moves from the input
// to the result register, with byte history, counters and the 28-byte payload
// store updated in that single pass. A result waiting in the output register
// blocks only the next item to leave the input register; a stalled output
// backs up into in_ready after one item. Config writes are always ready and
// must only happen while the block is idle. No clearing pass after reset.
module sensor_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sfr_pkg::sfr_in_t                  in_item,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output sfr_pkg::sfr_out_t                 out_item,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data
);

	// ---------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------
	logic [30:0] encoder_limit_q;
	logic [31:0] timeout_ticks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoder_limit_q <= sfr_pkg::ENCODER_LIMIT_RST;
			timeout_ticks_q <= sfr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfr_pkg::CFG_ENCODER_LIMIT: encoder_limit_q <= cfg_data[30:0];
				sfr_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic             valid_s1;
	sfr_pkg::sfr_in_t item_s1;
	logic             s1_go;      // item in s1 is processed this cycle
	logic             out_valid_q;

	// The s1 item may produce a result, so it only moves when the
	// output register is free or being emptied.
	assign s1_go    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// ---------------------------------------------------------------
	// Parser state
	// ---------------------------------------------------------------
	logic [7:0]  hist_q [3];   // [0] one byte back, [2] three back
	logic        in_frame_q;
	logic [7:0]  frame_length_q;
	logic [7:0]  byte_count_q;
	logic [31:0] tick_count_q;
	logic [7:0]  store_q    [sfr_pkg::STORE_DEPTH];
	logic [7:0]  store_next [sfr_pkg::STORE_DEPTH];

	logic        is_tick;
	logic [31:0] tick_inc;
	logic        timeout_hit;
	logic        sync_seen;
	logic        len_ok;
	logic        frame_active;
	logic [7:0]  count_base;
	logic [7:0]  count_inc;
	logic [7:0]  len_eff;
	logic        frame_done;
	logic        store_wr;
	logic [sfr_pkg::STORE_IDX_W-1:0] store_idx;

	assign is_tick     = (item_s1.action == sfr_pkg::ACT_TICK);
	assign tick_inc    = tick_count_q + 32'd1;
	assign timeout_hit = is_tick && (tick_inc >= timeout_ticks_q);

	// Sync pattern sits in the history when the current byte arrives
	assign sync_seen = (hist_q[2] == sfr_pkg::SYNC_FIRST) &&
	                   (hist_q[1] == sfr_pkg::SYNC_SECOND);
	assign len_ok    = (hist_q[0] != 8'd0) && (hist_q[0] <= sfr_pkg::PAYLOAD_MAX);

	assign frame_active = sync_seen ? len_ok : in_frame_q;
	assign count_base   = sync_seen ? 8'd0 : byte_count_q;
	assign len_eff      = sync_seen ? hist_q[0] : frame_length_q;
	assign count_inc    = count_base + 8'd1;
	assign frame_done   = !is_tick && frame_active && (count_inc == len_eff);
	assign store_wr     = !is_tick && frame_active &&
	                      (count_base < 8'(sfr_pkg::STORE_DEPTH));
	assign store_idx    = count_base[sfr_pkg::STORE_IDX_W-1:0];

	// Store contents after this byte: cleared on sync, then the byte lands
	always_comb begin
		for (int i = 0; i < sfr_pkg::STORE_DEPTH; i++) begin
			store_next[i] = sync_seen ? 8'd0 : store_q[i];
			if (store_wr && (store_idx == sfr_pkg::STORE_IDX_W'(i))) begin
				store_next[i] = item_s1.rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				hist_q[i] <= 8'd0;
			end
			in_frame_q     <= 1'b0;
			frame_length_q <= 8'd0;
			byte_count_q   <= 8'd0;
			tick_count_q   <= 32'd0;
		end else if (s1_go) begin
			if (timeout_hit || frame_done) begin
				// restart; the completing byte is not kept in the history
				for (int i = 0; i < 3; i++) begin
					hist_q[i] <= 8'd0;
				end
				in_frame_q     <= 1'b0;
				frame_length_q <= 8'd0;
				byte_count_q   <= 8'd0;
				tick_count_q   <= 32'd0;
			end else if (is_tick) begin
				tick_count_q <= tick_inc;
			end else begin
				hist_q[2]      <= hist_q[1];
				hist_q[1]      <= hist_q[0];
				hist_q[0]      <= item_s1.rx_byte;
				in_frame_q     <= frame_active;
				frame_length_q <= sync_seen ? (len_ok ? hist_q[0] : 8'd0) : frame_length_q;
				byte_count_q   <= frame_active ? count_inc : count_base;
			end
		end
	end

	// Store survives restarts; it is only ever read after a sync clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfr_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= 8'd0;
			end
		end else if (s1_go && !is_tick) begin
			for (int i = 0; i < sfr_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= store_next[i];
			end
		end
	end

	// ---------------------------------------------------------------
	// Result decode and output register
	// ---------------------------------------------------------------
	function automatic logic [31:0] limit_delta(input logic [31:0] raw,
	                                            input logic [30:0] lim);
		logic signed [32:0] v;
		logic signed [32:0] pos_lim;
		logic signed [32:0] neg_lim;
		begin
			v       = {raw[31], raw};
			pos_lim = {2'b00, lim};
			neg_lim = -pos_lim;
			limit_delta = ((v > pos_lim) || (v < neg_lim)) ? 32'd0 : raw;
		end
	endfunction

	sfr_pkg::sfr_out_t res_data;
	sfr_pkg::sfr_out_t out_item_q;
	logic              res_load;

	assign res_load = s1_go && (timeout_hit || frame_done);

	always_comb begin
		res_data = '0;
		if (is_tick) begin
			res_data.status = sfr_pkg::STATUS_TIMEOUT;
		end else begin
			res_data.status       = sfr_pkg::STATUS_FRAME;
			res_data.left_delta   = limit_delta({store_next[3], store_next[2],
			                                     store_next[1], store_next[0]},
			                                    encoder_limit_q);
			res_data.right_delta  = limit_delta({store_next[7], store_next[6],
			                                     store_next[5], store_next[4]},
			                                    encoder_limit_q);
			res_data.battery_word = {store_next[11], store_next[10],
			                         store_next[9],  store_next[8]};
			res_data.accel_x      = {store_next[13], store_next[12]};
			res_data.accel_y      = {store_next[15], store_next[14]};
			res_data.accel_z      = {store_next[17], store_next[16]};
			res_data.gyro_x       = {store_next[19], store_next[18]};
			res_data.gyro_y       = {store_next[21], store_next[20]};
			res_data.gyro_z       = {store_next[23], store_next[22]};
			res_data.mag_x        = {store_next[25], store_next[24]};
			res_data.mag_y        = {store_next[27], store_next[26]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_item_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_frame_len_sane: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (frame_length_q != 8'd0) &&
		               (frame_length_q <= sfr_pkg::PAYLOAD_MAX) &&
		               (byte_count_q < frame_length_q))
		else $error("frame in progress with bad length or count");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (byte_count_q == 8'd0))
		else $error("byte count nonzero outside a frame");

	a_restart_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> !in_frame_q && (tick_count_q == 32'd0) && out_valid_q)
		else $error("parser not restarted after result");

	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.status == sfr_pkg::STATUS_TIMEOUT) |->
		(out_item_q.left_delta == 32'sd0) && (out_item_q.battery_word == 32'd0) &&
		(out_item_q.mag_y == 16'sd0))
		else $error("timeout result carries data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !res_load)
		else $error("result register overwritten while stalled");

endmodule
